// File: design/bfi_pkg.sv
// Shared types and constants of the Brainfuck interpreter core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bfi_pkg;

  // Default storage sizes
  localparam int DefProgDepth = 4096;
  localparam int DefTapeDepth = 4096;

  // Field widths of the stream words
  localparam int ReqW      = 2;
  localparam int AddrFieldW = 12;
  localparam int ByteW     = 8;
  localparam int LenW      = 13;
  localparam int StatW     = 2;
  localparam int STdataW   = 32;
  localparam int MTdataW   = 24;

  // Request codes
  localparam logic [ReqW-1:0] REQ_LOAD    = 2'd0;
  localparam logic [ReqW-1:0] REQ_STEP    = 2'd1;
  localparam logic [ReqW-1:0] REQ_RESTART = 2'd2;

  // Run status codes
  localparam logic [StatW-1:0] RUN_ACTIVE = 2'd0;
  localparam logic [StatW-1:0] RUN_DONE   = 2'd1;
  localparam logic [StatW-1:0] RUN_ERROR  = 2'd2;

  // Command characters
  localparam logic [ByteW-1:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [ByteW-1:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [ByteW-1:0] CH_CLOSE = 8'h5D;  // ']'

  // Program read address select
  localparam logic [1:0] PRD_PC  = 2'd0;
  localparam logic [1:0] PRD_K   = 2'd1;
  localparam logic [1:0] PRD_KM1 = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch_item;
    logic       restart;
    logic       clr_init;
    logic       clr_step;
    logic       load_wr;
    logic       exec_fetch;
    logic       set_halt_end;
    logic       set_halt_err;
    logic [1:0] prog_rd;
    logic       dec_k;
    logic       scan_fwd;
    logic       scan_bwd;
    logic       out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            halted;
    logic            at_end;
    logic            op_open;
    logic            op_close;
    logic            hit_fwd;
    logic            hit_bwd;
    logic            k_at_len;
    logic            k_zero;
    logic            clr_done;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/bfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the program store and the tape; depends on nothing.
`default_nettype none

module bfi_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/bfi_ctrl.sv
// Controller state machine of the Brainfuck interpreter core.
// Depends on bfi_pkg; drives the datapath by commands and reads its status.
`default_nettype none

module bfi_ctrl
  import bfi_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_LOAD    = 4'd3;
  localparam logic [3:0] S_RCLR    = 4'd4;
  localparam logic [3:0] S_EXEC    = 4'd5;
  localparam logic [3:0] S_FETCH   = 4'd6;
  localparam logic [3:0] S_FWD_RD  = 4'd7;
  localparam logic [3:0] S_FWD_CHK = 4'd8;
  localparam logic [3:0] S_BWD_RD  = 4'd9;
  localparam logic [3:0] S_BWD_CHK = 4'd10;
  localparam logic [3:0] S_POST    = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  logic [3:0] state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.prog_rd = PRD_PC;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.req)
          REQ_LOAD: state_d = S_LOAD;
          REQ_STEP: state_d = S_EXEC;
          REQ_RESTART: begin
            cmd_o.restart  = 1'b1;
            cmd_o.clr_init = 1'b1;
            state_d = S_RCLR;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d = S_RESP;
      end
      S_RCLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_RESP;
      end
      S_EXEC: begin
        if (stat_i.halted) begin
          state_d = S_RESP;
        end else if (stat_i.at_end) begin
          cmd_o.set_halt_end = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.exec_fetch = 1'b1;
        if (stat_i.op_open) state_d = S_FWD_RD;
        else if (stat_i.op_close) state_d = S_BWD_RD;
        else state_d = S_POST;
      end
      S_FWD_RD: begin
        if (stat_i.k_at_len) begin
          cmd_o.set_halt_err = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.prog_rd = PRD_K;
          state_d = S_FWD_CHK;
        end
      end
      S_FWD_CHK: begin
        cmd_o.scan_fwd = 1'b1;
        state_d = stat_i.hit_fwd ? S_POST : S_FWD_RD;
      end
      S_BWD_RD: begin
        if (stat_i.k_zero) begin
          cmd_o.set_halt_err = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.prog_rd = PRD_KM1;
          cmd_o.dec_k   = 1'b1;
          state_d = S_BWD_CHK;
        end
      end
      S_BWD_CHK: begin
        cmd_o.scan_bwd = 1'b1;
        state_d = stat_i.hit_bwd ? S_POST : S_BWD_RD;
      end
      S_POST: begin
        cmd_o.set_halt_end = stat_i.at_end;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bfi_dp.sv
// Datapath of the Brainfuck interpreter core: program store, tape, pointers,
// bracket scanner and output register. Depends on bfi_pkg and bfi_ram.
`default_nettype none

module bfi_dp
  import bfi_pkg::*;
#(
  parameter int ProgDepth = DefProgDepth,
  parameter int TapeDepth = DefTapeDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LenW-1:0]    cfg_wdata_i,
  input  wire logic [STdataW-1:0] s_tdata_i,
  input  wire logic [ReqW-1:0]    s_tuser_i,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_stat_t                stat_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [MTdataW-1:0]      m_tdata_o,
  output logic                    m_tuser_o
);

  localparam int PAW  = $clog2(ProgDepth);
  localparam int TAW  = $clog2(TapeDepth);
  localparam int PcW  = PAW + 1;
  localparam int LW   = (PcW > LenW) ? PcW : LenW;
  localparam int AXW  = (PAW > AddrFieldW) ? PAW : AddrFieldW;

  // Item, configuration and machine state
  logic [ReqW-1:0]       req_q;
  logic [AddrFieldW-1:0] addr_q;
  logic [ByteW-1:0]      pbyte_q;
  logic [ByteW-1:0]      ibyte_q;
  logic [LenW-1:0]       len_q;
  logic [PcW-1:0]        pc_q, pc_d;
  logic [TAW-1:0]        dp_q, dp_d;
  logic [StatW-1:0]      halt_q, halt_d;
  logic [PcW-1:0]        k_q, k_d;
  logic [PcW-1:0]        depth_q, depth_d;
  logic                  cond_q, cond_d;
  logic                  valid_q, valid_d;
  logic [ByteW-1:0]      obyte_q, obyte_d;
  logic [TAW-1:0]        clr_q;

  // Output register
  logic                  m_valid_q;
  logic [ByteW-1:0]      m_byte_q;
  logic [StatW-1:0]      m_stat_q;
  logic [LenW-1:0]       m_pc_q;
  logic                  m_user_q;

  // Memory ports
  logic                  prog_we;
  logic [PAW-1:0]        prog_waddr, prog_raddr;
  logic [ByteW-1:0]      prog_rdata;
  logic                  tape_we;
  logic [TAW-1:0]        tape_waddr;
  logic [ByteW-1:0]      tape_wdata, tape_rdata;

  logic [LW-1:0]         len_ext, eff_ext, pc_ext;
  logic [PcW-1:0]        eff_len;
  logic [PcW-1:0]        km1;
  logic [AXW-1:0]        addr_ext;

  // Effective program length is capped at the store depth
  assign len_ext = LW'(len_q);
  assign eff_ext = (len_ext > LW'(ProgDepth)) ? LW'(ProgDepth) : len_ext;
  assign eff_len = eff_ext[PcW-1:0];
  assign pc_ext  = LW'(pc_q);
  assign km1     = k_q - 1'b1;
  assign addr_ext = AXW'(addr_q);

  // Program store: loads write, execution and scanning read
  assign prog_we    = cmd_i.load_wr && (32'(addr_q) < ProgDepth);
  assign prog_waddr = addr_ext[PAW-1:0];

  always_comb begin
    unique case (cmd_i.prog_rd)
      PRD_PC:  prog_raddr = pc_q[PAW-1:0];
      PRD_K:   prog_raddr = k_q[PAW-1:0];
      PRD_KM1: prog_raddr = km1[PAW-1:0];
      default: prog_raddr = pc_q[PAW-1:0];
    endcase
  end

  bfi_ram #(
    .Width(ByteW),
    .Depth(ProgDepth)
  ) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(pbyte_q),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  // Tape: the clearing sweep or a cell update writes, the data pointer reads
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = dp_q;
    tape_wdata = '0;
    if (cmd_i.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_q;
    end else if (cmd_i.exec_fetch) begin
      unique case (prog_rdata)
        CH_PLUS: begin
          tape_we    = 1'b1;
          tape_wdata = tape_rdata + 1'b1;
        end
        CH_MINUS: begin
          tape_we    = 1'b1;
          tape_wdata = tape_rdata - 1'b1;
        end
        CH_COMMA: begin
          tape_we    = 1'b1;
          tape_wdata = ibyte_q;
        end
        default: tape_we = 1'b0;
      endcase
    end
  end

  bfi_ram #(
    .Width(ByteW),
    .Depth(TapeDepth)
  ) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(dp_q),
    .rdata_o(tape_rdata)
  );

  // Execute, scan and update the machine state
  always_comb begin
    pc_d    = pc_q;
    dp_d    = dp_q;
    halt_d  = halt_q;
    k_d     = k_q;
    depth_d = depth_q;
    cond_d  = cond_q;
    valid_d = valid_q;
    obyte_d = obyte_q;

    if (cmd_i.latch_item) begin
      valid_d = 1'b0;
      obyte_d = '0;
    end

    if (cmd_i.restart) begin
      pc_d   = '0;
      dp_d   = '0;
      halt_d = RUN_ACTIVE;
    end

    if (cmd_i.exec_fetch) begin
      unique case (prog_rdata)
        CH_RIGHT: begin
          if (dp_q < TAW'(TapeDepth - 1)) dp_d = dp_q + 1'b1;
          pc_d = pc_q + 1'b1;
        end
        CH_LEFT: begin
          if (dp_q != '0) dp_d = dp_q - 1'b1;
          pc_d = pc_q + 1'b1;
        end
        CH_DOT: begin
          valid_d = 1'b1;
          obyte_d = tape_rdata;
          pc_d    = pc_q + 1'b1;
        end
        CH_OPEN: begin
          cond_d  = (tape_rdata == '0);
          k_d     = pc_q + 1'b1;
          depth_d = '0;
        end
        CH_CLOSE: begin
          cond_d  = (tape_rdata != '0);
          k_d     = pc_q;
          depth_d = '0;
        end
        default: pc_d = pc_q + 1'b1;
      endcase
    end

    // Step back one byte while seeking an open bracket
    if (cmd_i.dec_k) k_d = km1;

    // Forward seek: count nesting, jump past the partner when the cell is zero
    if (cmd_i.scan_fwd) begin
      k_d = k_q + 1'b1;
      if (prog_rdata == CH_OPEN) begin
        depth_d = depth_q + 1'b1;
      end else if (prog_rdata == CH_CLOSE) begin
        if (depth_q == '0) pc_d = cond_q ? (k_q + 1'b1) : (pc_q + 1'b1);
        else depth_d = depth_q - 1'b1;
      end
    end

    // Backward seek: jump to the partner when the cell is nonzero
    if (cmd_i.scan_bwd) begin
      if (prog_rdata == CH_CLOSE) begin
        depth_d = depth_q + 1'b1;
      end else if (prog_rdata == CH_OPEN) begin
        if (depth_q == '0) pc_d = cond_q ? k_q : (pc_q + 1'b1);
        else depth_d = depth_q - 1'b1;
      end
    end

    if (cmd_i.set_halt_end) halt_d = RUN_DONE;
    if (cmd_i.set_halt_err) halt_d = RUN_ERROR;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pc_q      <= '0;
      dp_q      <= '0;
      halt_q    <= RUN_ACTIVE;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      pc_q   <= pc_d;
      dp_q   <= dp_d;
      halt_q <= halt_d;
      if (cmd_i.clr_init) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.out_load) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      req_q   <= s_tuser_i;
      addr_q  <= s_tdata_i[AddrFieldW-1:0];
      pbyte_q <= s_tdata_i[AddrFieldW +: ByteW];
      ibyte_q <= s_tdata_i[AddrFieldW+ByteW +: ByteW];
    end
    k_q     <= k_d;
    depth_q <= depth_d;
    cond_q  <= cond_d;
    valid_q <= valid_d;
    obyte_q <= obyte_d;
    if (cmd_i.out_load) begin
      m_user_q <= valid_q;
      m_byte_q <= obyte_q;
      m_stat_q <= halt_q;
      m_pc_q   <= pc_ext[LenW-1:0];
    end
  end

  // Status to the controller
  assign stat_o.req      = req_q;
  assign stat_o.halted   = (halt_q != RUN_ACTIVE);
  assign stat_o.at_end   = (pc_q >= eff_len);
  assign stat_o.op_open  = (prog_rdata == CH_OPEN);
  assign stat_o.op_close = (prog_rdata == CH_CLOSE);
  assign stat_o.hit_fwd  = (prog_rdata == CH_CLOSE) && (depth_q == '0);
  assign stat_o.hit_bwd  = (prog_rdata == CH_OPEN) && (depth_q == '0);
  assign stat_o.k_at_len = (k_q >= eff_len);
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.clr_done = (clr_q == TAW'(TapeDepth - 1));
  assign stat_o.out_free = !m_valid_q || m_tready_i;

  // Result word
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {1'b0, m_pc_q, m_stat_q, m_byte_q};
  assign m_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// File: design/brainfuck_interpreter_core.sv
// Top level of the Brainfuck interpreter core.
// Depends on bfi_pkg, bfi_ctrl, bfi_dp and bfi_ram.
//
// Each input word is one request: load a program byte, execute one
// instruction, or restart (clear tape, data pointer, program counter and
// status; the program is kept). Every request returns exactly one result word
// with the output byte of '.', the run status and the program counter after
// the request. Requests are handled one at a time by a sequencer around a
// program RAM and a tape RAM, both with registered reads. A step while
// halted or already at the program end executes no instruction. A bracket
// walks the program RAM byte by byte, up to its partner, or up to the
// program end or start when it has none. A restart runs a clearing pass
// over the whole tape. After reset the same clearing pass runs before the
// first word is accepted; configuration writes are taken at any time. The
// result sits in an output register, so the next request is accepted while
// it waits to be taken.
`default_nettype none

module brainfuck_interpreter_core
  import bfi_pkg::*;
#(
  parameter int ProgDepth = DefProgDepth,
  parameter int TapeDepth = DefTapeDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // program_length register
  input  wire logic               cfg_we_i,
  input  wire logic [LenW-1:0]    cfg_wdata_i,
  // Request stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // prog_addr[11:0], prog_byte[19:12], in_byte[27:20], zero[31:28]
  input  wire logic [STdataW-1:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [ReqW-1:0]    s_axis_tuser,
  // Result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // out_byte[7:0], run_status[9:8], next_pc[22:10], zero[23]
  output logic [MTdataW-1:0]      m_axis_tdata,
  // out_valid[0]
  output logic                    m_axis_tuser
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  bfi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Memories, pointers and result register
  bfi_dp #(
    .ProgDepth(ProgDepth),
    .TapeDepth(TapeDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
